// ===== src/single_tone_lock_in_measure_defines.svh =====
// Assertion macros shared by the lock-in measurement RTL.
`ifndef SINGLE_TONE_LOCK_IN_MEASURE_DEFINES_SVH
`define SINGLE_TONE_LOCK_IN_MEASURE_DEFINES_SVH

// Check a property on every rising clk_i edge outside reset.
`define STLIM_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check that a condition implies a consequence in the next cycle.
`define STLIM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/stlim_pkg.sv =====
// Package with types, constants and the sine table of the lock-in measurement block.
package stlim_pkg;

  localparam int COUNT_BITS      = 24;
  localparam int SAMPLE_BITS     = 16;
  localparam int SINE_TABLE_BITS = 10;

  localparam int SINE_BITS       = 16;
  localparam int SUM_BITS        = 56;
  localparam int PHASE_BITS      = 32;
  localparam int PHASE_INC_BITS  = 31;
  localparam int BIAS_BITS       = 16;
  localparam int AMP_BITS        = 15;
  localparam int LIMIT_BITS      = 15;
  localparam int CFG_IDX_BITS    = 3;
  localparam int CFG_DATA_BITS   = 32;

  localparam int unsigned QUARTER_LEN = 1 << (SINE_TABLE_BITS - 2);
  localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

  typedef enum logic [2:0] {
    MODE_IDLE     = 3'd0,
    MODE_READY    = 3'd1,
    MODE_WARMUP   = 3'd2,
    MODE_MEASURE  = 3'd3,
    MODE_COMPLETE = 3'd4,
    MODE_ERROR    = 3'd5
  } mode_e;

  typedef enum logic [1:0] {
    FAULT_OK       = 2'd0,
    FAULT_VOLTAGE  = 2'd1,
    FAULT_OVERFLOW = 2'd2
  } fault_e;

  typedef enum logic {
    ACTION_TICK  = 1'b0,
    ACTION_START = 1'b1
  } action_e;

  // Configuration register indexes
  localparam logic [CFG_IDX_BITS-1:0] REG_PHASE_INCREMENT = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_WARMUP_LENGTH   = 3'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_MEASURE_LENGTH  = 3'd2;
  localparam logic [CFG_IDX_BITS-1:0] REG_DRIVE_BIAS      = 3'd3;
  localparam logic [CFG_IDX_BITS-1:0] REG_DRIVE_AMPLITUDE = 3'd4;
  localparam logic [CFG_IDX_BITS-1:0] REG_VOLTAGE_LIMIT   = 3'd5;

  typedef logic [SINE_BITS-1:0] quarter_rom_t [0:QUARTER_LEN];

  // Build the quarter wave with a fixed-point Taylor series in Q30.
  function automatic quarter_rom_t build_quarter();
    quarter_rom_t     rom;
    longint unsigned  x;
    longint unsigned  x2;
    longint unsigned  term;
    longint unsigned  acc;
    longint unsigned  v;
    for (int r = 0; r <= int'(QUARTER_LEN); r++) begin
      x    = (HALF_PI_Q30 * longint'(r)) / QUARTER_LEN;
      x2   = (x * x) >> 30;
      term = x;
      acc  = x;
      for (int n = 1; n <= 5; n++) begin
        term = (term * x2) >> 30;
        case (n)
          1:       term = term / 6;
          2:       term = term / 20;
          3:       term = term / 42;
          4:       term = term / 72;
          default: term = term / 110;
        endcase
        if ((n % 2) == 1) acc = acc - term;
        else              acc = acc + term;
      end
      v = (acc * 64'd32767 + (64'd1 << 29)) >> 30;
      if (v > 64'd32767) v = 64'd32767;
      rom[r] = v[SINE_BITS-1:0];
    end
    return rom;
  endfunction

  localparam quarter_rom_t QUARTER_ROM = build_quarter();

  // Full-wave sine from the quarter table by symmetry.
  function automatic logic signed [SINE_BITS-1:0] rom_sine(
    input logic [SINE_TABLE_BITS-1:0] k
  );
    logic [1:0]                 quad;
    logic [SINE_TABLE_BITS-3:0] r;
    logic [SINE_TABLE_BITS-2:0] idx;
    logic signed [SINE_BITS-1:0] mag;
    quad = k[SINE_TABLE_BITS-1 -: 2];
    r    = k[SINE_TABLE_BITS-3:0];
    if (quad[0]) idx = (SINE_TABLE_BITS-1)'(QUARTER_LEN) - {1'b0, r};
    else         idx = {1'b0, r};
    mag = $signed(QUARTER_ROM[idx]);
    return quad[1] ? -mag : mag;
  endfunction

endpackage

// ===== src/stlim_if.sv =====
// Channel interfaces: sample requests, result requests and configuration writes.
interface stlim_in_if;
  logic                                       valid;
  logic                                       ready;
  logic                                       action;
  logic signed [stlim_pkg::SAMPLE_BITS-1:0]   voltage;

  modport source (output valid, action, voltage, input ready);
  modport sink   (input valid, action, voltage, output ready);
endinterface

interface stlim_out_if;
  logic                                       valid;
  logic                                       ready;
  logic signed [stlim_pkg::SINE_BITS-1:0]     modulation;
  logic [2:0]                                 state_code;
  logic [1:0]                                 status_code;
  logic signed [stlim_pkg::SUM_BITS-1:0]      in_phase_sum;
  logic signed [stlim_pkg::SUM_BITS-1:0]      quadrature_sum;
  logic [stlim_pkg::COUNT_BITS-1:0]           measured_count;

  modport source (output valid, modulation, state_code, status_code, in_phase_sum,
                  quadrature_sum, measured_count, input ready);
  modport sink   (input valid, modulation, state_code, status_code, in_phase_sum,
                  quadrature_sum, measured_count, output ready);
endinterface

interface stlim_cfg_if;
  logic                                       valid;
  logic                                       ready;
  logic [stlim_pkg::CFG_IDX_BITS-1:0]         index;
  logic [stlim_pkg::CFG_DATA_BITS-1:0]        data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== src/single_tone_lock_in_measure.sv =====
// Top level of the single-tone lock-in measurement block.
//
// Usage:
//   in_i   carries one request per converter sample: action tick with a voltage,
//          or action start, which clears the run and arms the block.
//   out_o  returns exactly one result request per input request: the suggested
//          drive value (modulation), the mode, the status and the two lock-in sums
//          with the number of samples accumulated.
//   cfg_i  writes one register per request (always ready); write only while no
//          request is in flight.
// Pipeline: input register, then result register, loaded when free or taken.
// Throughput: one request per cycle while out_o keeps taking results. The input
//   register feeds table lookup, three independent multiplies and 56-bit sum adds.
// Stall: when out_o is held off, the result register and the input register
//   both hold and in_i drops ready once both are full.
// Reset: mode idle, sums, counters and phase cleared, registers at defaults;
//   the sine table is constant logic, so no fill time follows reset.
module single_tone_lock_in_measure (
  input  logic               clk_i,
  input  logic               rst_ni,
  stlim_in_if.sink           in_i,
  stlim_out_if.source        out_o,
  stlim_cfg_if.sink          cfg_i
);
  import stlim_pkg::*;

  `include "single_tone_lock_in_measure_defines.svh"

  // Configuration registers
  logic [PHASE_INC_BITS-1:0]      phase_increment_q;
  logic [COUNT_BITS-1:0]          warmup_length_q;
  logic [COUNT_BITS-1:0]          measure_length_q;
  logic signed [BIAS_BITS-1:0]    drive_bias_q;
  logic [AMP_BITS-1:0]            drive_amplitude_q;
  logic [LIMIT_BITS-1:0]          voltage_limit_q;

  // Input register
  logic                           s1_valid_q, s1_valid_d;
  logic                           s1_action_q;
  logic signed [SAMPLE_BITS-1:0]  s1_voltage_q;

  // Run state
  mode_e                          mode_q, mode_d;
  fault_e                         fault_q, fault_d;
  logic [PHASE_BITS-1:0]          phase_acc_q, phase_acc_d;
  logic signed [SINE_BITS-1:0]    ref_sine_q, ref_sine_d;
  logic signed [SINE_BITS-1:0]    ref_cosine_q, ref_cosine_d;
  logic signed [SUM_BITS-1:0]     sine_acc_q, sine_acc_d;
  logic signed [SUM_BITS-1:0]     cosine_acc_q, cosine_acc_d;
  logic [COUNT_BITS-1:0]          warmup_done_q, warmup_done_d;
  logic [COUNT_BITS-1:0]          measure_done_q, measure_done_d;

  // Result register
  logic                           out_valid_q;
  logic signed [SINE_BITS-1:0]    out_mod_q, out_mod_d;

  // Step control
  logic                           advance;
  logic                           step;
  logic                           in_accept;
  logic                           do_start;
  logic                           do_emit;
  logic                           do_warm;
  logic                           do_accum;

  // Datapath
  logic [SINE_TABLE_BITS-1:0]     tab_idx;
  logic signed [SINE_BITS-1:0]    tab_sine;
  logic signed [SINE_BITS-1:0]    tab_cosine;
  logic signed [31:0]             amp_prod;
  logic signed [31:0]             amp_round;
  logic signed [BIAS_BITS+1:0]    mod_wide;
  logic signed [SINE_BITS-1:0]    mod_emit;
  logic [SAMPLE_BITS:0]           v_abs;
  logic                           v_over;
  logic signed [SAMPLE_BITS+SINE_BITS-1:0] vs_prod;
  logic signed [SAMPLE_BITS+SINE_BITS-1:0] vc_prod;
  logic signed [SUM_BITS:0]       sine_next;
  logic signed [SUM_BITS:0]       cosine_next;
  logic                           sum_ovf;
  logic [COUNT_BITS-1:0]          warm_inc;
  logic [COUNT_BITS-1:0]          meas_inc;

  // Handshake: the pipeline moves when the result register is free or taken
  assign advance      = !out_valid_q || out_o.ready;
  assign in_i.ready   = !s1_valid_q || advance;
  assign in_accept    = in_i.valid && in_i.ready;
  assign step         = s1_valid_q && advance;
  assign cfg_i.ready  = 1'b1;

  // Sine table lookup at the current phase
  assign tab_idx    = phase_acc_q[PHASE_BITS-1 -: SINE_TABLE_BITS];
  assign tab_sine   = rom_sine(tab_idx);
  assign tab_cosine = rom_sine(tab_idx + SINE_TABLE_BITS'(QUARTER_LEN));

  // Modulation: bias plus rounded amplitude times sine, saturated
  always_comb begin
    amp_prod  = $signed({1'b0, drive_amplitude_q}) * tab_sine;
    amp_round = (amp_prod + 32'sd16384) >>> 15;
    mod_wide  = (BIAS_BITS+2)'(drive_bias_q) + $signed(amp_round[BIAS_BITS+1:0]);
    if (mod_wide > (BIAS_BITS+2)'(32767)) begin
      mod_emit = 16'sh7FFF;
    end else if (mod_wide < -(BIAS_BITS+2)'(32768)) begin
      mod_emit = 16'sh8000;
    end else begin
      mod_emit = mod_wide[SINE_BITS-1:0];
    end
  end

  // Voltage check, lock-in products and overflow check
  always_comb begin
    v_abs       = s1_voltage_q[SAMPLE_BITS-1] ? -(SAMPLE_BITS+1)'(s1_voltage_q)
                                              : (SAMPLE_BITS+1)'(s1_voltage_q);
    v_over      = v_abs > (SAMPLE_BITS+1)'(voltage_limit_q);
    vs_prod     = s1_voltage_q * ref_sine_q;
    vc_prod     = s1_voltage_q * ref_cosine_q;
    sine_next   = (SUM_BITS+1)'(sine_acc_q) + (SUM_BITS+1)'(vs_prod);
    cosine_next = (SUM_BITS+1)'(cosine_acc_q) + (SUM_BITS+1)'(vc_prod);
    sum_ovf     = (sine_next[SUM_BITS] != sine_next[SUM_BITS-1]) ||
                  (cosine_next[SUM_BITS] != cosine_next[SUM_BITS-1]);
    warm_inc    = warmup_done_q + COUNT_BITS'(1);
    meas_inc    = measure_done_q + COUNT_BITS'(1);
  end

  // Next mode and fault
  always_comb begin
    mode_d   = mode_q;
    fault_d  = fault_q;
    do_start = 1'b0;
    do_emit  = 1'b0;
    do_warm  = 1'b0;
    do_accum = 1'b0;
    if (s1_action_q == ACTION_START) begin
      do_start = 1'b1;
      mode_d   = MODE_READY;
      fault_d  = FAULT_OK;
    end else begin
      case (mode_q)
        MODE_READY: begin
          mode_d  = (warmup_length_q != '0) ? MODE_WARMUP : MODE_MEASURE;
          do_emit = 1'b1;
        end
        MODE_WARMUP: begin
          if (v_over) begin
            mode_d  = MODE_ERROR;
            fault_d = FAULT_VOLTAGE;
          end else begin
            do_warm = 1'b1;
            do_emit = 1'b1;
            if (warm_inc >= warmup_length_q) mode_d = MODE_MEASURE;
          end
        end
        MODE_MEASURE: begin
          if (v_over) begin
            mode_d  = MODE_ERROR;
            fault_d = FAULT_VOLTAGE;
          end else if (sum_ovf) begin
            mode_d  = MODE_ERROR;
            fault_d = FAULT_OVERFLOW;
          end else begin
            do_accum = 1'b1;
            if (meas_inc >= measure_length_q) begin
              mode_d  = MODE_COMPLETE;
              fault_d = FAULT_OK;
            end else begin
              do_emit = 1'b1;
            end
          end
        end
        default: begin
          mode_d = mode_q;
        end
      endcase
    end
  end

  // Datapath updates and result value
  always_comb begin
    phase_acc_d    = phase_acc_q;
    ref_sine_d     = ref_sine_q;
    ref_cosine_d   = ref_cosine_q;
    sine_acc_d     = sine_acc_q;
    cosine_acc_d   = cosine_acc_q;
    warmup_done_d  = warmup_done_q;
    measure_done_d = measure_done_q;
    out_mod_d      = drive_bias_q;
    if (do_start) begin
      phase_acc_d    = '0;
      ref_sine_d     = '0;
      ref_cosine_d   = '0;
      sine_acc_d     = '0;
      cosine_acc_d   = '0;
      warmup_done_d  = '0;
      measure_done_d = '0;
    end
    if (do_warm) begin
      warmup_done_d = warm_inc;
    end
    if (do_accum) begin
      sine_acc_d     = sine_next[SUM_BITS-1:0];
      cosine_acc_d   = cosine_next[SUM_BITS-1:0];
      measure_done_d = meas_inc;
    end
    if (do_emit) begin
      out_mod_d    = mod_emit;
      ref_sine_d   = tab_sine;
      ref_cosine_d = tab_cosine;
      phase_acc_d  = phase_acc_q + {1'b0, phase_increment_q};
    end
  end

  // Input register
  always_comb begin
    if (in_accept)    s1_valid_d = 1'b1;
    else if (advance) s1_valid_d = 1'b0;
    else              s1_valid_d = s1_valid_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_action_q  <= in_i.action;
      s1_voltage_q <= in_i.voltage;
    end
  end

  // Configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_increment_q <= PHASE_INC_BITS'(1);
      warmup_length_q   <= '0;
      measure_length_q  <= COUNT_BITS'(1);
      drive_bias_q      <= '0;
      drive_amplitude_q <= AMP_BITS'(1);
      voltage_limit_q   <= LIMIT_BITS'(32767);
    end else if (cfg_i.valid && cfg_i.ready) begin
      case (cfg_i.index)
        REG_PHASE_INCREMENT: phase_increment_q <= cfg_i.data[PHASE_INC_BITS-1:0];
        REG_WARMUP_LENGTH:   warmup_length_q   <= cfg_i.data[COUNT_BITS-1:0];
        REG_MEASURE_LENGTH:  measure_length_q  <= cfg_i.data[COUNT_BITS-1:0];
        REG_DRIVE_BIAS:      drive_bias_q      <= $signed(cfg_i.data[BIAS_BITS-1:0]);
        REG_DRIVE_AMPLITUDE: drive_amplitude_q <= cfg_i.data[AMP_BITS-1:0];
        REG_VOLTAGE_LIMIT:   voltage_limit_q   <= cfg_i.data[LIMIT_BITS-1:0];
        default: ;
      endcase
    end
  end

  // Run state and result register advance together
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q         <= MODE_IDLE;
      fault_q        <= FAULT_OK;
      phase_acc_q    <= '0;
      ref_sine_q     <= '0;
      ref_cosine_q   <= '0;
      sine_acc_q     <= '0;
      cosine_acc_q   <= '0;
      warmup_done_q  <= '0;
      measure_done_q <= '0;
      out_valid_q    <= 1'b0;
    end else if (step) begin
      mode_q         <= mode_d;
      fault_q        <= fault_d;
      phase_acc_q    <= phase_acc_d;
      ref_sine_q     <= ref_sine_d;
      ref_cosine_q   <= ref_cosine_d;
      sine_acc_q     <= sine_acc_d;
      cosine_acc_q   <= cosine_acc_d;
      warmup_done_q  <= warmup_done_d;
      measure_done_q <= measure_done_d;
      out_valid_q    <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q    <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      out_mod_q <= out_mod_d;
    end
  end

  // Result fields: the state registers change only when a new result loads
  assign out_o.valid          = out_valid_q;
  assign out_o.modulation     = out_mod_q;
  assign out_o.state_code     = mode_q;
  assign out_o.status_code    = fault_q;
  assign out_o.in_phase_sum   = sine_acc_q;
  assign out_o.quadrature_sum = cosine_acc_q;
  assign out_o.measured_count = measure_done_q;

  `STLIM_ASSERT(a_fault_only_in_error, (fault_q == FAULT_OK) || (mode_q == MODE_ERROR),
                "fault code set outside error mode")
  `STLIM_ASSERT(a_idle_sums_clear,
                (mode_q != MODE_IDLE) || ((sine_acc_q == '0) && (cosine_acc_q == '0)),
                "sums nonzero while idle")
  `STLIM_ASSERT(a_count_mode, (measure_done_q == '0) || (mode_q == MODE_MEASURE) ||
                (mode_q == MODE_COMPLETE) || (mode_q == MODE_ERROR),
                "measured count nonzero before measuring")
  `STLIM_ASSERT_NEXT(a_stall_holds_input, s1_valid_q && out_valid_q && !out_o.ready,
                     s1_valid_q, "pending request dropped during stall")

endmodule

// ===== sim/lock_in_checker.sv =====
// Checker for the lock-in measurement block: predicts each result and compares it.
module lock_in_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  stlim_in_if         in_i,
  stlim_out_if        out_i,
  stlim_cfg_if        cfg_i,
  output int unsigned fail_count_o,
  output int unsigned pending_o
);
  timeunit 1ns;
  timeprecision 1ps;
  import stlim_pkg::*;

  localparam longint SUM_HI = (longint'(1) << (SUM_BITS - 1)) - 1;
  localparam longint SUM_LO = -(longint'(1) << (SUM_BITS - 1));

  typedef struct packed {
    logic signed [SINE_BITS-1:0] modulation;
    mode_e                       state;
    fault_e                      status;
    logic [SUM_BITS-1:0]         in_phase;
    logic [SUM_BITS-1:0]         quadrature;
    logic [COUNT_BITS-1:0]       count;
  } lock_in_result_t;

  lock_in_result_t expected_results[$];

  // Register copies
  logic [PHASE_INC_BITS-1:0]   cfg_step;
  logic [COUNT_BITS-1:0]       cfg_warmup;
  logic [COUNT_BITS-1:0]       cfg_measure;
  logic signed [BIAS_BITS-1:0] cfg_bias;
  logic [AMP_BITS-1:0]         cfg_amp;
  logic [LIMIT_BITS-1:0]       cfg_limit;

  // Measurement state
  mode_e                       pred_mode;
  fault_e                      pred_fault;
  logic [PHASE_BITS-1:0]       phase_acc;
  logic signed [SINE_BITS-1:0] ref_sine;
  logic signed [SINE_BITS-1:0] ref_cosine;
  longint                      in_phase_acc;
  longint                      quadrature_acc;
  logic [COUNT_BITS-1:0]       warmup_count;
  logic [COUNT_BITS-1:0]       measure_count;

  int quarter_wave [0:QUARTER_LEN];

  // Fill the quarter wave with a Q30 Taylor series of the sine
  initial begin : fill_quarter_wave
    longint unsigned x;
    longint unsigned x2;
    longint unsigned term;
    longint unsigned acc;
    longint unsigned v;
    for (int r = 0; r <= int'(QUARTER_LEN); r++) begin
      x    = (HALF_PI_Q30 * 64'(r)) / QUARTER_LEN;
      x2   = (x * x) >> 30;
      term = x;
      acc  = x;
      for (int n = 1; n <= 5; n++) begin
        term = (term * x2) >> 30;
        term = term / 64'((2 * n) * (2 * n + 1));
        if (n % 2 == 1) acc = acc - term;
        else            acc = acc + term;
      end
      v = (acc * 64'd32767 + (64'd1 << 29)) >> 30;
      quarter_wave[r] = (v > 64'd32767) ? 32767 : int'(v);
    end
  end

  // Full-wave sine by quarter symmetry
  function automatic logic signed [SINE_BITS-1:0] table_sine(
    input logic [SINE_TABLE_BITS-1:0] k
  );
    logic [1:0] quad;
    int         offs;
    int         mag;
    quad = k[SINE_TABLE_BITS-1 -: 2];
    offs = int'(k[SINE_TABLE_BITS-3:0]);
    mag  = quad[0] ? quarter_wave[QUARTER_LEN - offs] : quarter_wave[offs];
    return SINE_BITS'(quad[1] ? -mag : mag);
  endfunction

  // Produce the drive value, latch the references and advance the phase
  function automatic logic signed [SINE_BITS-1:0] step_oscillator();
    logic [SINE_TABLE_BITS-1:0]  k;
    logic signed [SINE_BITS-1:0] s;
    logic signed [SINE_BITS-1:0] c;
    longint                      m;
    k = phase_acc[PHASE_BITS-1 -: SINE_TABLE_BITS];
    s = table_sine(k);
    c = table_sine(k + SINE_TABLE_BITS'(QUARTER_LEN));
    m = longint'(cfg_bias) + ((longint'(cfg_amp) * longint'(s) + 64'sd16384) >>> 15);
    if (m > 32767)       m = 32767;
    else if (m < -32768) m = -32768;
    ref_sine   = s;
    ref_cosine = c;
    phase_acc  = phase_acc + PHASE_BITS'(cfg_step);
    return m[SINE_BITS-1:0];
  endfunction

  function automatic void clear_run();
    pred_fault     = FAULT_OK;
    phase_acc      = '0;
    ref_sine       = '0;
    ref_cosine     = '0;
    in_phase_acc   = 0;
    quadrature_acc = 0;
    warmup_count   = '0;
    measure_count  = '0;
  endfunction

  // Advance the measurement by one request and return its result
  function automatic lock_in_result_t lock_in_step(
    input action_e                       act,
    input logic signed [SAMPLE_BITS-1:0] volt
  );
    lock_in_result_t             res;
    logic signed [SINE_BITS-1:0] drive;
    longint                      v;
    longint                      mag_v;
    longint                      next_ip;
    longint                      next_q;
    drive = cfg_bias;
    v     = longint'(volt);
    mag_v = (v < 0) ? -v : v;
    if (act == ACTION_START) begin
      clear_run();
      pred_mode = MODE_READY;
    end else if (pred_mode == MODE_READY) begin
      pred_mode = (cfg_warmup != '0) ? MODE_WARMUP : MODE_MEASURE;
      drive     = step_oscillator();
    end else if (pred_mode == MODE_WARMUP || pred_mode == MODE_MEASURE) begin
      if (mag_v > longint'(cfg_limit)) begin
        pred_mode  = MODE_ERROR;
        pred_fault = FAULT_VOLTAGE;
      end else if (pred_mode == MODE_WARMUP) begin
        warmup_count = warmup_count + 1'b1;
        if (warmup_count >= cfg_warmup) pred_mode = MODE_MEASURE;
        drive = step_oscillator();
      end else begin
        next_ip = in_phase_acc + v * longint'(ref_sine);
        next_q  = quadrature_acc + v * longint'(ref_cosine);
        if (next_ip > SUM_HI || next_ip < SUM_LO || next_q > SUM_HI || next_q < SUM_LO) begin
          pred_mode  = MODE_ERROR;
          pred_fault = FAULT_OVERFLOW;
        end else begin
          in_phase_acc   = next_ip;
          quadrature_acc = next_q;
          measure_count  = measure_count + 1'b1;
          if (measure_count >= cfg_measure) begin
            pred_mode  = MODE_COMPLETE;
            pred_fault = FAULT_OK;
          end else begin
            drive = step_oscillator();
          end
        end
      end
    end
    res.modulation = drive;
    res.state      = pred_mode;
    res.status     = pred_fault;
    res.in_phase   = in_phase_acc[SUM_BITS-1:0];
    res.quadrature = quadrature_acc[SUM_BITS-1:0];
    res.count      = measure_count;
    return res;
  endfunction

  task automatic check_field(input string field, input logic [63:0] want,
                             input logic [63:0] got);
    if (want !== got) begin
      fail_count_o++;
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, field, want, got);
    end
  endtask

  // Watch the channels: predict on each accepted request, compare on each result and copy register writes
  always @(posedge clk_i or negedge rst_ni) begin
    lock_in_result_t want;
    if (!rst_ni) begin
      cfg_step     = 1;
      cfg_warmup   = 0;
      cfg_measure  = 1;
      cfg_bias     = 0;
      cfg_amp      = 1;
      cfg_limit    = 15'h7FFF;
      pred_mode    = MODE_IDLE;
      clear_run();
      expected_results.delete();
      fail_count_o = 0;
      pending_o    = 0;
    end else begin
      if (in_i.valid === 1'b1 && in_i.ready === 1'b1)
        expected_results.push_back(lock_in_step(action_e'(in_i.action), in_i.voltage));
      if (out_i.valid === 1'b1 && out_i.ready === 1'b1) begin
        if (expected_results.size() == 0) begin
          fail_count_o++;
          $display("%0t: result with no request pending, expected none, got state %0h",
                   $time, out_i.state_code);
        end else begin
          want = expected_results.pop_front();
          check_field("modulation", 64'(want.modulation), 64'(out_i.modulation));
          check_field("state_code", 64'(want.state), 64'(out_i.state_code));
          check_field("status_code", 64'(want.status), 64'(out_i.status_code));
          check_field("in_phase_sum", 64'(want.in_phase), 64'(unsigned'(out_i.in_phase_sum)));
          check_field("quadrature_sum", 64'(want.quadrature),
                      64'(unsigned'(out_i.quadrature_sum)));
          check_field("measured_count", 64'(want.count), 64'(out_i.measured_count));
        end
      end
      if (cfg_i.valid === 1'b1 && cfg_i.ready === 1'b1) begin
        case (cfg_i.index)
          REG_PHASE_INCREMENT: cfg_step    = cfg_i.data[PHASE_INC_BITS-1:0];
          REG_WARMUP_LENGTH:   cfg_warmup  = cfg_i.data[COUNT_BITS-1:0];
          REG_MEASURE_LENGTH:  cfg_measure = cfg_i.data[COUNT_BITS-1:0];
          REG_DRIVE_BIAS:      cfg_bias    = cfg_i.data[BIAS_BITS-1:0];
          REG_DRIVE_AMPLITUDE: cfg_amp     = cfg_i.data[AMP_BITS-1:0];
          REG_VOLTAGE_LIMIT:   cfg_limit   = cfg_i.data[LIMIT_BITS-1:0];
          default: ;
        endcase
      end
      pending_o = expected_results.size();
    end
  end

endmodule

// ===== sim/testbench.sv =====
// Top of the lock-in measurement testbench: clock, reset, stimulus and verdict.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import stlim_pkg::*;

  localparam logic [CFG_IDX_BITS-1:0] REG_UNUSED = 3'd7;

  typedef struct {
    logic [CFG_IDX_BITS-1:0]  index;
    logic [CFG_DATA_BITS-1:0] data;
  } cfg_write_t;

  logic clk = 1'b0;
  logic rst_n;

  int unsigned mismatch_count;
  int unsigned pending_results;

  int unsigned burst_left;
  int unsigned work_items;
  int          cur_warmup;
  int          cur_measure;
  int          cur_limit;

  stlim_in_if  in_ch();
  stlim_out_if out_ch();
  stlim_cfg_if cfg_ch();

  single_tone_lock_in_measure u_top (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (in_ch),
    .out_o  (out_ch),
    .cfg_i  (cfg_ch)
  );

  lock_in_checker u_checker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_i         (in_ch),
    .out_i        (out_ch),
    .cfg_i        (cfg_ch),
    .fail_count_o (mismatch_count),
    .pending_o    (pending_results)
  );

  always #2 clk = ~clk;

  // Drop the run if it hangs
  initial begin : watchdog
    #2_000_000;
    $display("Some tests failed");
    $finish;
  end

  // Stall the result side on a changing pattern, with one long hold-off now and then
  initial begin : result_side
    int unsigned cyc;
    int unsigned style;
    int unsigned hold_left;
    cyc       = 0;
    style     = 0;
    hold_left = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      cyc++;
      if (cyc % 2500 == 1200) hold_left = 180;
      if (cyc % 64 == 0) style = $urandom_range(0, 3);
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        case (style)
          0:       out_ch.ready <= 1'b1;
          1:       out_ch.ready <= 1'($urandom_range(0, 1));
          2:       out_ch.ready <= ($urandom_range(0, 3) == 0);
          default: out_ch.ready <= (cyc % 5 != 0);
        endcase
      end
    end
  end

  // Offer one request in bursts with random gaps; hold until it is taken
  task automatic send_request(input action_e act, input logic signed [SAMPLE_BITS-1:0] volt);
    if (burst_left == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120)
                                               : $urandom_range(1, 12);
    end
    burst_left--;
    in_ch.valid   <= 1'b1;
    in_ch.action  <= act;
    in_ch.voltage <= volt;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
  endtask

  // Drop the input and wait until every result has come back
  task automatic wait_idle();
    in_ch.valid <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (pending_results != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  function automatic logic [CFG_DATA_BITS-1:0] field_bits(
    input logic [31:0] value, input int width, input bit noisy
  );
    logic [31:0] mask;
    mask = (32'd1 << width) - 32'd1;
    return noisy ? (($urandom() & ~mask) | (value & mask)) : (value & mask);
  endfunction

  // Write all registers once the block is idle
  task automatic program_settings(
    input int unsigned step, input int unsigned warm, input int unsigned meas,
    input int bias, input int unsigned amp, input int unsigned limit,
    input bit noisy, input bit touch_unused
  );
    cfg_write_t writes[$];
    wait_idle();
    writes.push_back('{REG_PHASE_INCREMENT, field_bits(step, PHASE_INC_BITS, noisy)});
    writes.push_back('{REG_WARMUP_LENGTH, field_bits(warm, COUNT_BITS, noisy)});
    writes.push_back('{REG_MEASURE_LENGTH, field_bits(meas, COUNT_BITS, noisy)});
    writes.push_back('{REG_DRIVE_BIAS, field_bits(32'(bias), BIAS_BITS, noisy)});
    writes.push_back('{REG_DRIVE_AMPLITUDE, field_bits(amp, AMP_BITS, noisy)});
    writes.push_back('{REG_VOLTAGE_LIMIT, field_bits(limit, LIMIT_BITS, noisy)});
    if (touch_unused) writes.push_back('{REG_UNUSED, $urandom()});
    foreach (writes[i]) begin
      cfg_ch.valid <= 1'b1;
      cfg_ch.index <= writes[i].index;
      cfg_ch.data  <= writes[i].data;
      do @(posedge clk); while (cfg_ch.ready !== 1'b1);
    end
    cfg_ch.valid <= 1'b0;
    cur_warmup  = int'(warm & 32'hFF_FFFF);
    cur_measure = int'(meas & 32'hFF_FFFF);
    cur_limit   = int'(limit & 32'h7FFF);
  endtask

  initial begin : stimulus
    int unsigned step;
    int unsigned warm;
    int unsigned meas;
    int unsigned amp;
    int unsigned limit;
    int unsigned planned;
    int unsigned mag;
    int          bias;
    int          volt;

    rst_n         <= 1'b0;
    in_ch.valid   <= 1'b0;
    in_ch.action  <= ACTION_TICK;
    in_ch.voltage <= '0;
    cfg_ch.valid  <= 1'b0;
    cfg_ch.index  <= REG_PHASE_INCREMENT;
    cfg_ch.data   <= '0;
    burst_left  = 0;
    work_items  = 0;
    cur_warmup  = 0;
    cur_measure = 1;
    cur_limit   = 32767;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset settings: tick while idle, a one-sample run, tick once complete
    send_request(ACTION_TICK, 16'sd0);
    send_request(ACTION_START, 16'sd0);
    send_request(ACTION_TICK, 16'sd0);
    send_request(ACTION_TICK, 16'sd32767);
    send_request(ACTION_TICK, 16'sd5);

    // Largest step, lowest bias, voltage right at and just past the limit
    program_settings(32'h7FFF_FFFF, 2, 3, -32768, 32767, 100, 1'b0, 1'b1);
    send_request(ACTION_START, 16'sd0);
    send_request(ACTION_TICK, 16'sh8000);
    send_request(ACTION_TICK, 16'sd100);
    send_request(ACTION_TICK, -16'sd100);
    send_request(ACTION_TICK, 16'sd5);
    send_request(ACTION_TICK, 16'sd101);
    send_request(ACTION_TICK, 16'sd0);
    send_request(ACTION_START, 16'sd0);
    send_request(ACTION_TICK, 16'sd1);
    send_request(ACTION_TICK, -16'sd101);

    // Frozen phase, zero lengths, saturating drive, most negative voltage
    program_settings(0, 0, 0, 32767, 32767, 32767, 1'b0, 1'b0);
    send_request(ACTION_START, 16'sd0);
    send_request(ACTION_TICK, 16'sd32767);
    send_request(ACTION_TICK, 16'sh8000);
    send_request(ACTION_START, 16'sd0);
    send_request(ACTION_TICK, 16'sd0);
    send_request(ACTION_TICK, -16'sd32767);

    // Longest lengths, zero amplitude and limit, restart during warmup
    program_settings(32'h4000_0000, 24'hFF_FFFF, 24'hFF_FFFF, 0, 0, 0, 1'b1, 1'b0);
    send_request(ACTION_START, 16'sd0);
    send_request(ACTION_TICK, -16'sd7);
    send_request(ACTION_TICK, 16'sd0);
    send_request(ACTION_START, 16'sd0);
    send_request(ACTION_TICK, 16'sd0);
    send_request(ACTION_TICK, 16'sd1);

    // Random settings, each followed by a few measurement runs
    while (work_items < 1550) begin
      case ($urandom_range(0, 4))
        0:       step = 1;
        1:       step = 32'h7FFF_FFFF;
        2:       step = 0;
        3:       step = $urandom_range(1, 4096);
        default: step = $urandom() & 32'h7FFF_FFFF;
      endcase
      case ($urandom_range(0, 9))
        0:       warm = 0;
        1:       warm = 24'hFF_FFFF;
        default: warm = $urandom_range(1, 6);
      endcase
      case ($urandom_range(0, 9))
        0:       meas = 0;
        1:       meas = 24'hFF_FFFF;
        2:       meas = 1;
        default: meas = $urandom_range(2, 40);
      endcase
      case ($urandom_range(0, 5))
        0:       bias = -32768;
        1:       bias = 32767;
        2:       bias = 0;
        default: bias = int'($urandom_range(0, 65535)) - 32768;
      endcase
      case ($urandom_range(0, 5))
        0:       amp = 32767;
        1:       amp = 1;
        2:       amp = 0;
        default: amp = $urandom_range(0, 32767);
      endcase
      case ($urandom_range(0, 5))
        0, 1:    limit = 32767;
        2:       limit = 0;
        3:       limit = $urandom_range(1, 64);
        default: limit = $urandom_range(1, 32767);
      endcase
      program_settings(step, warm, meas, bias, amp, limit, $urandom_range(0, 3) == 0, 1'b0);

      repeat ($urandom_range(2, 6)) begin
        if ($urandom_range(0, 5) == 0) send_request(ACTION_TICK, 16'($urandom()));
        send_request(ACTION_START, 16'($urandom()));
        work_items++;
        planned = 1 + ((cur_warmup > 10) ? 10 : cur_warmup)
                    + ((cur_measure > 40) ? 40 : ((cur_measure == 0) ? 1 : cur_measure));
        for (int i = 0; i < int'(planned); i++) begin
          if (i == 0) begin
            // the first tick after a start leaves ready unchecked
            volt = int'($urandom_range(0, 65535)) - 32768;
          end else if ($urandom_range(0, 99) == 0) begin
            // push past the limit
            if (cur_limit >= 32767) begin
              volt = -32768;
            end else begin
              mag  = $urandom_range(cur_limit + 1, 32768);
              volt = (mag == 32768 || $urandom_range(0, 1) == 1) ? -int'(mag) : int'(mag);
            end
          end else begin
            case ($urandom_range(0, 9))
              0:       volt = cur_limit;
              1:       volt = -cur_limit;
              default: volt = int'($urandom_range(0, 2 * cur_limit)) - cur_limit;
            endcase
          end
          if ($urandom_range(0, 79) == 0) send_request(ACTION_START, 16'(volt));
          else                            send_request(ACTION_TICK, 16'(volt));
          work_items++;
        end
        repeat ($urandom_range(0, 2)) send_request(ACTION_TICK, 16'($urandom()));
      end
    end

    // Drain and give the verdict
    wait_idle();
    repeat (8) @(posedge clk);
    if (mismatch_count == 0 && pending_results == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
